// File: hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// Concurrent check, also evaluated during reset.
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

// File: hw/rtl/rlsaf_pkg.sv
// Types, constants and fixed-point helpers for the RLS adaptive filter.
package rlsaf_pkg;

   localparam logic signed [31:0] ONE_Q24     = 32'sd16777216;
   localparam logic signed [31:0] P_INIT_Q24  = 32'sd838861;
   localparam logic [14:0]        GAMMA_RESET = 15'd32440;

   typedef struct packed {
      logic               start;
      logic signed [63:0] numer;
      logic signed [63:0] denom;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic signed [31:0] quot;
   } div_rsp_type;

   // Add half an LSB, then shift toward minus infinity.
   function automatic logic signed [63:0] rshift(input logic signed [63:0] v, input int s);
      logic signed [63:0] half;
      half = 64'sd1 <<< (s - 1);
      return (v + half) >>> s;
   endfunction

   function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
      if (v > 64'sd2147483647) begin
         return 32'sh7fff_ffff;
      end else if (v < -64'sd2147483648) begin
         return 32'sh8000_0000;
      end else begin
         return v[31:0];
      end
   endfunction

   function automatic logic signed [15:0] sat16(input logic signed [63:0] v);
      if (v > 64'sd32767) begin
         return 16'sh7fff;
      end else if (v < -64'sd32768) begin
         return 16'sh8000;
      end else begin
         return v[15:0];
      end
   endfunction

endpackage

// File: hw/rtl/rlsaf_div.sv
// Sequential restoring divider: signed numerator, positive divisor, saturated 32-bit quotient.
module rlsaf_div (
   input  logic                  clock,
   input  logic                  reset,
   input  rlsaf_pkg::div_req_type req,
   output rlsaf_pkg::div_rsp_type rsp
);

   logic        busy_ff;
   logic        done_ff;
   logic        neg_ff;
   logic        ovf_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] rem_ff;
   logic [95:0] dsh_ff;
   logic [31:0] q_ff;
   logic signed [31:0] quot_ff;

   logic [63:0] mag;
   logic [63:0] dmag;
   logic        ge;
   logic [63:0] rem_in;
   logic [31:0] q_in;
   logic signed [31:0] quot_in;

   always_comb begin
      mag    = req.numer[63] ? 64'(-req.numer) : 64'(req.numer);
      dmag   = 64'(req.denom);
      ge     = {32'b0, rem_ff} >= dsh_ff;
      rem_in = ge ? (rem_ff - dsh_ff[63:0]) : rem_ff;
      q_in   = {q_ff[30:0], ge};
      if (neg_ff) begin
         quot_in = (ovf_ff || (q_in > 32'h8000_0000)) ? 32'sh8000_0000 : 32'(-q_in);
      end else begin
         quot_in = (ovf_ff || q_in[31]) ? 32'sh7fff_ffff : 32'(q_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            neg_ff  <= req.numer[63];
            rem_ff  <= mag;
            dsh_ff  <= {32'b0, dmag} << 31;
            ovf_ff  <= {32'b0, mag} >= {dmag, 32'b0};
            q_ff    <= '0;
            cnt_ff  <= 5'd31;
            busy_ff <= 1'b1;
         end else if (busy_ff) begin
            rem_ff <= rem_in;
            q_ff   <= q_in;
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - 5'd1;
            if (cnt_ff == 5'd0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
               quot_ff <= quot_in;
            end
         end
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = quot_ff;

endmodule

// File: hw/rtl/rls_adaptive_filter.sv
// Top level of the recursive least squares adaptive FIR filter.
//
//   channel  direction  handshake          payload
//   req      in         req_valid/stall    req_sample, req_desired (Q1.15)
//   rsp      out        rsp_valid/stall    rsp_error (Q1.15, saturated)
//   csr      in         csr_valid/ready    csr_forgetting_factor (Q0.15)
//
// Operation: one transaction at a time, paced by the single 32x32 MAC and the bit-serial
// divider, which computes each gain and each P element.
// Reset: synchronous; afterwards a clearing pass over the TAPS^2 elements of P loads P and
// the weights, during which req_stall stays high. csr writes are always taken.
// Stalls: the error goes out early through an output register; a stalled result
// holds the sequencer before the P update starts.
module rls_adaptive_filter #(
   parameter int TAPS = 8
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_sample,
   input  logic signed [15:0] req_desired,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [15:0] rsp_error,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [14:0]        csr_forgetting_factor
);

   localparam int IA_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int PD   = TAPS * TAPS;
   localparam int PA_W = (PD > 1) ? $clog2(PD) : 1;
   localparam logic [IA_W-1:0] LAST = IA_W'(TAPS - 1);

   typedef enum logic [4:0] {
      S_CLEAR, S_IDLE,
      S_E_RD, S_E_MUL, S_E_ACC, S_E_DONE, S_OUT,
      S_A_RD, S_A_MUL, S_A_ACC,
      S_B_RD, S_B_MUL, S_B_ACC,
      S_F_MUL, S_F_ACC, S_F_DONE,
      S_G_START, S_G_WAIT,
      S_U_RD, S_U_MUL, S_U_DIV, S_U_WAIT,
      S_W_RD, S_W_MUL, S_W_WR
   } state_type;

   state_type          state_ff;
   logic [IA_W-1:0]    i_ff;
   logic [IA_W-1:0]    j_ff;
   logic signed [15:0] win_ff [TAPS];
   logic signed [15:0] desired_ff;
   logic signed [63:0] acc_ff;
   logic signed [63:0] prod_ff;
   logic signed [15:0] err_ff;
   logic signed [63:0] denom_ff;
   logic signed [31:0] px_ff [TAPS];
   logic signed [31:0] xp_ff [TAPS];
   logic signed [31:0] gain_ff [TAPS];
   logic [14:0]        gamma_ff;
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_error_ff;

   // P (row major) and weights
   logic signed [31:0] p_mem [PD];
   logic signed [31:0] w_mem [TAPS];
   logic signed [31:0] p_rd_ff;
   logic signed [31:0] w_rd_ff;

   logic               p_re, p_we, w_re, w_we;
   logic [PA_W-1:0]    p_raddr, p_waddr, row_addr, col_addr;
   logic signed [31:0] p_wdata, w_wdata, w_new;
   logic [IA_W-1:0]    x_idx;
   logic signed [15:0] x_sel;
   logic signed [31:0] mul_a, mul_b;
   logic signed [63:0] mul_p;
   logic signed [63:0] acc_sum;
   logic signed [63:0] t_val;
   logic [14:0]        gam_eff;
   logic               i_last, j_last;
   rlsaf_pkg::div_req_type div_req;
   rlsaf_pkg::div_rsp_type div_rsp;

   rlsaf_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   always_comb begin
      i_last   = (i_ff == LAST);
      j_last   = (j_ff == LAST);
      gam_eff  = (gamma_ff == 15'd0) ? 15'd1 : gamma_ff;
      row_addr = PA_W'(int'(i_ff) * TAPS + int'(j_ff));
      col_addr = PA_W'(int'(j_ff) * TAPS + int'(i_ff));
      // the P.X and X'.P passes walk X by the inner index j, everything else by i
      x_idx = (state_ff == S_A_MUL || state_ff == S_B_MUL) ? j_ff : i_ff;
      x_sel = win_ff[x_idx];
      acc_sum = acc_ff + prod_ff;

      t_val = {{32{p_rd_ff[31]}}, p_rd_ff} - rlsaf_pkg::rshift(prod_ff, 24);
      w_new = rlsaf_pkg::sat32({{32{w_rd_ff[31]}}, w_rd_ff} + rlsaf_pkg::rshift(prod_ff, 15));

      p_re    = (state_ff == S_A_RD) || (state_ff == S_B_RD) || (state_ff == S_U_RD);
      p_raddr = (state_ff == S_B_RD) ? col_addr : row_addr;
      p_we    = (state_ff == S_CLEAR) || ((state_ff == S_U_WAIT) && div_rsp.done);
      p_waddr = row_addr;
      if (state_ff == S_CLEAR) begin
         p_wdata = (i_ff == j_ff) ? rlsaf_pkg::P_INIT_Q24 : 32'sd0;
      end else begin
         p_wdata = div_rsp.quot;
      end

      w_re    = (state_ff == S_E_RD) || (state_ff == S_W_RD);
      w_we    = ((state_ff == S_CLEAR) && (j_ff == '0)) || (state_ff == S_W_WR);
      w_wdata = (state_ff == S_CLEAR) ? rlsaf_pkg::ONE_Q24 : w_new;

      case (state_ff)
         S_E_MUL: begin
            mul_a = w_rd_ff;
            mul_b = {{16{x_sel[15]}}, x_sel};
         end
         S_A_MUL, S_B_MUL: begin
            mul_a = p_rd_ff;
            mul_b = {{16{x_sel[15]}}, x_sel};
         end
         S_F_MUL: begin
            mul_a = px_ff[i_ff];
            mul_b = {{16{x_sel[15]}}, x_sel};
         end
         S_U_MUL: begin
            mul_a = gain_ff[i_ff];
            mul_b = xp_ff[j_ff];
         end
         S_W_MUL: begin
            mul_a = gain_ff[i_ff];
            mul_b = {{16{err_ff[15]}}, err_ff};
         end
         default: begin
            mul_a = 32'sd0;
            mul_b = 32'sd0;
         end
      endcase
      mul_p = mul_a * mul_b;

      // the P step divides by gamma, the gain step by the denominator
      div_req.start = ((state_ff == S_G_START) && (denom_ff > 64'sd0)) ||
                      (state_ff == S_U_DIV);
      if (state_ff == S_U_DIV) begin
         div_req.numer = t_val <<< 15;
         div_req.denom = {49'b0, gam_eff};
      end else begin
         div_req.numer = {{32{px_ff[i_ff][31]}}, px_ff[i_ff]} <<< 24;
         div_req.denom = denom_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         p_mem[p_waddr] <= p_wdata;
      end
      if (p_re) begin
         p_rd_ff <= p_mem[p_raddr];
      end
      if (w_we) begin
         w_mem[i_ff] <= w_wdata;
      end
      if (w_re) begin
         w_rd_ff <= w_mem[i_ff];
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= mul_p;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         i_ff         <= '0;
         j_ff         <= '0;
         rsp_valid_ff <= 1'b0;
         gamma_ff     <= rlsaf_pkg::GAMMA_RESET;
         for (int k = 0; k < TAPS; k++) begin
            win_ff[k] <= 16'sd0;
         end
      end else begin
         if (csr_valid && csr_ready) begin
            gamma_ff <= csr_forgetting_factor;
         end
         // S_OUT drives the flag itself
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               if (j_last) begin
                  j_ff <= '0;
                  if (i_last) begin
                     i_ff     <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end else begin
                  j_ff <= j_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  for (int k = TAPS - 1; k > 0; k--) begin
                     win_ff[k] <= win_ff[k-1];
                  end
                  win_ff[0]  <= req_sample;
                  desired_ff <= req_desired;
                  acc_ff     <= 64'sd0;
                  i_ff       <= '0;
                  j_ff       <= '0;
                  state_ff   <= S_E_RD;
               end
            end
            // a-priori estimate W.X
            S_E_RD:  state_ff <= S_E_MUL;
            S_E_MUL: state_ff <= S_E_ACC;
            S_E_ACC: begin
               acc_ff <= acc_sum;
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= S_E_DONE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_E_RD;
               end
            end
            S_E_DONE: begin
               err_ff <= rlsaf_pkg::sat16({{48{desired_ff[15]}}, desired_ff} -
                                          rlsaf_pkg::rshift(acc_ff, 24));
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_error_ff <= err_ff;
                  acc_ff       <= 64'sd0;
                  state_ff     <= S_A_RD;
               end
            end
            // P.X, row by row
            S_A_RD:  state_ff <= S_A_MUL;
            S_A_MUL: state_ff <= S_A_ACC;
            S_A_ACC: begin
               if (j_last) begin
                  px_ff[i_ff] <= rlsaf_pkg::sat32(rlsaf_pkg::rshift(acc_sum, 15));
                  acc_ff      <= 64'sd0;
                  j_ff        <= '0;
                  if (i_last) begin
                     i_ff     <= '0;
                     state_ff <= S_B_RD;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_A_RD;
                  end
               end else begin
                  acc_ff   <= acc_sum;
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_A_RD;
               end
            end
            // X'.P, column by column
            S_B_RD:  state_ff <= S_B_MUL;
            S_B_MUL: state_ff <= S_B_ACC;
            S_B_ACC: begin
               if (j_last) begin
                  xp_ff[i_ff] <= rlsaf_pkg::sat32(rlsaf_pkg::rshift(acc_sum, 15));
                  acc_ff      <= 64'sd0;
                  j_ff        <= '0;
                  if (i_last) begin
                     i_ff     <= '0;
                     state_ff <= S_F_MUL;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_B_RD;
                  end
               end else begin
                  acc_ff   <= acc_sum;
                  j_ff     <= j_ff + 1'b1;
                  state_ff <= S_B_RD;
               end
            end
            // quadratic form X'.(P.X)
            S_F_MUL: state_ff <= S_F_ACC;
            S_F_ACC: begin
               acc_ff <= acc_sum;
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= S_F_DONE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_F_MUL;
               end
            end
            S_F_DONE: begin
               denom_ff <= ({49'b0, gam_eff} <<< 9) + rlsaf_pkg::rshift(acc_ff, 15);
               state_ff <= S_G_START;
            end
            // gain; a non-positive denominator gives zero gain
            S_G_START: begin
               if (denom_ff > 64'sd0) begin
                  state_ff <= S_G_WAIT;
               end else begin
                  gain_ff[i_ff] <= 32'sd0;
                  if (i_last) begin
                     i_ff     <= '0;
                     j_ff     <= '0;
                     state_ff <= S_U_RD;
                  end else begin
                     i_ff <= i_ff + 1'b1;
                  end
               end
            end
            S_G_WAIT: begin
               if (div_rsp.done) begin
                  gain_ff[i_ff] <= div_rsp.quot;
                  if (i_last) begin
                     i_ff     <= '0;
                     j_ff     <= '0;
                     state_ff <= S_U_RD;
                  end else begin
                     i_ff     <= i_ff + 1'b1;
                     state_ff <= S_G_START;
                  end
               end
            end
            // P update; the write happens as the quotient arrives
            S_U_RD:  state_ff <= S_U_MUL;
            S_U_MUL: state_ff <= S_U_DIV;
            S_U_DIV: state_ff <= S_U_WAIT;
            S_U_WAIT: begin
               if (div_rsp.done) begin
                  if (j_last) begin
                     j_ff <= '0;
                     if (i_last) begin
                        i_ff     <= '0;
                        state_ff <= S_W_RD;
                     end else begin
                        i_ff     <= i_ff + 1'b1;
                        state_ff <= S_U_RD;
                     end
                  end else begin
                     j_ff     <= j_ff + 1'b1;
                     state_ff <= S_U_RD;
                  end
               end
            end
            // weight update W += G.e
            S_W_RD:  state_ff <= S_W_MUL;
            S_W_MUL: state_ff <= S_W_WR;
            S_W_WR: begin
               if (i_last) begin
                  i_ff     <= '0;
                  state_ff <= S_IDLE;
               end else begin
                  i_ff     <= i_ff + 1'b1;
                  state_ff <= S_W_RD;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_error = rsp_error_ff;
   assign csr_ready = 1'b1;

endmodule

// File: hw/rtl/rlsaf_checker.sv
// Port-level checks for the RLS adaptive filter, bound to the top level.
`include "assert_macros.svh"

module rlsaf_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic signed [15:0] rsp_error
);

   // a held result stays offered and unchanged
   `ASSERT_CLK(a_rsp_hold, clock, reset, rsp_valid && rsp_stall |=> rsp_valid)
   `ASSERT_CLK(a_rsp_stable, clock, reset, rsp_valid && rsp_stall |=> $stable(rsp_error))
   // one transaction at a time: busy right after taking one
   `ASSERT_CLK(a_busy_after_req, clock, reset, req_valid && !req_stall |=> req_stall)
   // the clearing pass keeps the input closed after reset
   `ASSERT_CLK_NR(a_stall_after_reset, clock, reset |=> req_stall)

endmodule

bind rls_adaptive_filter rlsaf_checker u_rlsaf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_error (rsp_error)
);
